[rtl/core/far_pkg.sv]
// Package for the fraction arithmetic block: widths, operation codes,
// payload words, controller states and command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package far_pkg;
	localparam int OPERAND_BITS_DEF = 16;
	localparam int NUM_W = 33;
	localparam int DEN_W = 31;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic signed [15:0] num_a;
		logic signed [15:0] den_a;
		logic signed [15:0] num_b;
		logic signed [15:0] den_b;
	} in_word_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] res_num;
		logic [DEN_W-1:0] res_den;
		logic is_whole;
		logic status;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic gcd_start;
		logic gcd_step;
		logic divn_start;
		logic divd_start;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic zero_den;
		logic gcd_done;
		logic div_done;
	} stat_t;
endpackage
`default_nettype wire

[rtl/core/far_ctrl.sv]
// Controller state machine for the fraction arithmetic block.
// Depends on far_pkg.
`timescale 1ns / 1ps
`default_nettype none
module far_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  far_pkg::stat_t    stat,
	output far_pkg::cmd_t     cmd
);
	far_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= far_pkg::ST_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			far_pkg::ST_IDLE: if (start) state_nx = far_pkg::ST_MUL;
			far_pkg::ST_MUL:  state_nx = far_pkg::ST_SUM;
			far_pkg::ST_SUM:  state_nx = stat.zero_den ? far_pkg::ST_DONE : far_pkg::ST_GCD;
			far_pkg::ST_GCD:  if (stat.gcd_done) state_nx = far_pkg::ST_DIVN;
			far_pkg::ST_DIVN: if (stat.div_done) state_nx = far_pkg::ST_DIVD;
			far_pkg::ST_DIVD: if (stat.div_done) state_nx = far_pkg::ST_DONE;
			far_pkg::ST_DONE: state_nx = far_pkg::ST_IDLE;
			default:          state_nx = far_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			far_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			far_pkg::ST_MUL: cmd.mul = 1'b1;
			far_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				cmd.gcd_start = !stat.zero_den;
			end
			far_pkg::ST_GCD: begin
				cmd.gcd_step = 1'b1;
				cmd.divn_start = stat.gcd_done;
			end
			far_pkg::ST_DIVN: begin
				cmd.div_step = 1'b1;
				cmd.divd_start = stat.div_done;
			end
			far_pkg::ST_DIVD: cmd.div_step = 1'b1;
			far_pkg::ST_DONE: cmd.emit = 1'b1;
			default: busy = 1'b1;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/far_dp.sv]
// Datapath: operand products, Euclid remainder loop built on one
// restoring bit-serial divider, then division of both parts. Depends on far_pkg.
`timescale 1ns / 1ps
`default_nettype none
module far_dp #(
	parameter int OPERAND_BITS = far_pkg::OPERAND_BITS_DEF
) (
	input  wire logic          clk,
	input  far_pkg::in_word_t  in_word,
	input  far_pkg::cmd_t      cmd,
	output far_pkg::stat_t     stat,
	output far_pkg::out_word_t out_word
);
	localparam int P = 2 * OPERAND_BITS;       // product width
	localparam int M = P + 1;                  // magnitude width
	localparam int CW = $clog2(M + 1);

	logic signed [OPERAND_BITS-1:0] na_q, da_q, nb_q, db_q;
	logic [1:0] op_q;
	logic signed [P-1:0] p1_q, p2_q, p3_q;
	logic signed [P:0] rn_w;
	logic signed [P-1:0] rd_w;
	logic neg_q, zero_q;
	logic [M-1:0] a_q, b_q, g_q, quo_q, rem_q, dvd_q, mn_q, md_q;
	logic [CW-1:0] cnt_q;
	logic div_run_q;
	logic [M-1:0] mn_w, md_w;
	logic [M:0] trial;

	// capture the operands at their parameter width
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_word.kind;
			na_q <= OPERAND_BITS'(in_word.num_a);
			da_q <= OPERAND_BITS'(in_word.den_a);
			nb_q <= OPERAND_BITS'(in_word.num_b);
			db_q <= OPERAND_BITS'(in_word.den_b);
		end
	end

	// cross products: one registered multiply each
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			case (far_pkg::op_t'(op_q))
				far_pkg::OP_MUL: begin
					p1_q <= P'(na_q * nb_q);
					p3_q <= P'(da_q * db_q);
				end
				far_pkg::OP_DIV: begin
					p1_q <= P'(na_q * db_q);
					p3_q <= P'(da_q * nb_q);
				end
				default: begin
					p1_q <= P'(na_q * db_q);
					p3_q <= P'(da_q * db_q);
				end
			endcase
			p2_q <= P'(nb_q * da_q);
		end
	end

	// raw numerator and denominator
	always_comb begin
		case (far_pkg::op_t'(op_q))
			far_pkg::OP_ADD: rn_w = (P+1)'(p1_q) + (P+1)'(p2_q);
			far_pkg::OP_SUB: rn_w = (P+1)'(p1_q) - (P+1)'(p2_q);
			default:         rn_w = (P+1)'(p1_q);
		endcase
		rd_w = p3_q;
		mn_w = rn_w[P] ? M'(-rn_w) : M'(rn_w);
		md_w = rd_w[P-1] ? M'(-(P+1)'(rd_w)) : M'(rd_w);
	end

	assign stat.zero_den = (rd_w == '0);

	// shared restoring divider step
	assign trial = {rem_q, dvd_q[M-1]} - {1'b0, b_q};

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			zero_q <= (rd_w == '0);
			neg_q <= rn_w[P] ^ rd_w[P-1];
			mn_q <= mn_w;
			md_q <= md_w;
			div_run_q <= 1'b0;
		end
		if (cmd.gcd_start) begin
			// Euclid: a is the divisor, g the dividend
			a_q <= mn_w;
			g_q <= md_w;
		end
		if (cmd.gcd_step) begin
			if (!div_run_q) begin
				if (a_q != '0) begin
					b_q <= a_q;
					dvd_q <= g_q;
					rem_q <= '0;
					cnt_q <= CW'(M);
					div_run_q <= 1'b1;
				end
			end else if (cnt_q != '0) begin
				if (!trial[M]) rem_q <= trial[M-1:0];
				else rem_q <= {rem_q[M-2:0], dvd_q[M-1]};
				dvd_q <= {dvd_q[M-2:0], !trial[M]};
				cnt_q <= cnt_q - 1'b1;
			end else begin
				g_q <= a_q;
				a_q <= rem_q;
				div_run_q <= 1'b0;
			end
		end
		if (cmd.divn_start) begin
			b_q <= g_q; dvd_q <= mn_q; rem_q <= '0;
			cnt_q <= CW'(M); div_run_q <= 1'b1;
		end else if (cmd.divd_start) begin
			mn_q <= dvd_q;
			b_q <= g_q; dvd_q <= md_q; rem_q <= '0;
			cnt_q <= CW'(M); div_run_q <= 1'b1;
		end else if (cmd.div_step) begin
			if (cnt_q != '0) begin
				if (!trial[M]) rem_q <= trial[M-1:0];
				else rem_q <= {rem_q[M-2:0], dvd_q[M-1]};
				dvd_q <= {dvd_q[M-2:0], !trial[M]};
				cnt_q <= cnt_q - 1'b1;
			end else begin
				quo_q <= dvd_q;
			end
		end
	end

	assign stat.gcd_done = cmd.gcd_step && !div_run_q && (a_q == '0);
	assign stat.div_done = cmd.div_step && (cnt_q == '0);

	// result word
	always_comb begin
		logic [M-1:0] sn;
		sn = neg_q ? -mn_q : mn_q;
		out_word.res_num = zero_q ? '0 : far_pkg::NUM_W'(signed'(sn));
		out_word.res_den = zero_q ? '0 : far_pkg::DEN_W'(quo_q);
		out_word.is_whole = !zero_q && (quo_q == M'(1));
		out_word.status = zero_q;
	end
endmodule
`default_nettype wire

[rtl/core/fraction_arith_reduce.sv]
// Top level of the fraction arithmetic block: controller plus datapath.
// Depends on far_pkg, far_ctrl, far_dp.
//
// channel  | ports                  | handshake
// command  | start, busy, in_word   | taken when start && !busy
// result   | done, out_word         | one-cycle strobe, no back-pressure
//
// A word goes through the accepting cycle, the product and sum states, then Euclid:
// per remainder one bit-serial division and a check for a zero remainder, then
// two divisions of the numerator and denominator by the gcd and the strobe, busy
// high throughout. A zero denominator goes from the sum state straight to the
// strobe. The result port never stalls; a new word can be taken the cycle after
// the strobe. Reset clears the controller only.
`timescale 1ns / 1ps
`default_nettype none
module fraction_arith_reduce #(
	parameter int OPERAND_BITS = far_pkg::OPERAND_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  far_pkg::in_word_t  in_word,
	output logic               done,
	output far_pkg::out_word_t out_word
);
	far_pkg::cmd_t  cmd;
	far_pkg::stat_t stat;

	far_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .cmd(cmd)
	);

	far_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
		.clk(clk), .in_word(in_word), .cmd(cmd), .stat(stat), .out_word(out_word)
	);

	assign done = cmd.emit;
endmodule
`default_nettype wire
